// ----- rtl/itoa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEXL = 3'd2;
  localparam logic [2:0] OP_HEXU = 3'd3;
  localparam logic [2:0] OP_PTR  = 3'd4;

  localparam int unsigned MaxDigits = 16;
  localparam int unsigned DigIdxW   = $clog2(MaxDigits);

  // ceil(2^35 / 10): x / 10 == (x * RECIP10) >> 35 for every 32-bit x
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_HEX,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [7:0] char_out;
    logic [4:0] position;
    logic       last;
  } beat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (nib < 4'd10) begin
      digit_char = CH_ZERO + {4'b0, nib};
    end else begin
      digit_char = base + {4'b0, nib} - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/integer_to_ascii_formatter.sv -----
// Integer to ASCII formatter.
// Input channel (in_valid_i / in_stall_o) takes one beat of op_i and value_i;
// the output channel (out_valid_o / out_stall_i) returns one beat per
// character, most significant first, with position_o counting from zero and
// last_o marking the final character. op_i values 5 to 7 give no beats.
// Decimal digits come from the divider unit, a registered reciprocal
// multiply by 1/10 (up to 10 digits); hex modes shift out one nibble per
// cycle (up to 16 digits). Characters then leave through an output
// register at one per cycle while out_stall_i is low.
// in_stall_o stays high from an accepted beat with op_i 0 to 4 until its
// last character is loaded into the output register; the next item may
// start converting while that last character still waits on out_stall_i.
// A stalled output beat holds; emission simply pauses.
// Reset clears the sequencer and the output valid; the block is idle after.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [7:0]  char_out_o,
  output logic      [4:0]  position_o,
  output logic             last_o
);
  import itoa_pkg::*;

  state_e state_q, state_d;

  logic [63:0] work_q, work_d;
  logic [3:0]  dig_q [MaxDigits];
  logic [4:0]  ndig_q, ndig_d;
  logic [4:0]  pos_q, pos_d;
  logic [1:0]  pre_q, pre_d;
  logic        neg_q, neg_d;
  logic        upper_q, upper_d;
  logic        dig_we;
  logic [3:0]  dig_wdata;

  logic        in_acc;
  logic [31:0] low;
  logic [31:0] mag;
  logic [31:0] quot;
  logic [3:0]  rem;

  logic        ob_ready;
  logic        ob_load;
  beat_t       beat_d;
  beat_t       beat_o;

  logic [4:0]  len;
  logic [4:0]  didx;
  logic        is_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign low        = value_i[31:0];
  assign mag        = (op_i == OP_SDEC && low[31]) ? (32'd0 - low) : low;

  itoa_divu u_divu (
    .clk_i  (clk_i),
    .x_i    (work_q[31:0]),
    .quot_o (quot),
    .rem_o  (rem)
  );

  assign len     = {3'b0, pre_q} + ndig_q;
  assign didx    = ndig_q - 5'd1 - (pos_q - {3'b0, pre_q});
  assign is_last = (pos_q == len - 5'd1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_i) inside
            OP_SDEC, OP_UDEC:         state_d = ST_MUL;
            OP_HEXL, OP_HEXU, OP_PTR: state_d = ST_HEX;
            default:                  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  state_d = (quot == 32'd0) ? ST_EMIT : ST_MUL;
      ST_HEX:  state_d = (work_q[63:4] == 60'd0) ? ST_EMIT : ST_HEX;
      ST_EMIT: begin
        if (ob_ready && is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    work_d    = work_q;
    ndig_d    = ndig_q;
    pos_d     = pos_q;
    pre_d     = pre_q;
    neg_d     = neg_q;
    upper_d   = upper_q;
    dig_we    = 1'b0;
    dig_wdata = rem;
    ob_load   = 1'b0;
    beat_d.position = pos_q;
    beat_d.last     = is_last;
    if (pos_q < {3'b0, pre_q}) begin
      beat_d.char_out = neg_q ? CH_MINUS : (pos_q[0] ? CH_X : CH_ZERO);
    end else begin
      beat_d.char_out = digit_char(dig_q[didx[DigIdxW-1:0]], upper_q);
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ndig_d  = 5'd0;
          pos_d   = 5'd0;
          upper_d = (op_i == OP_HEXU);
          neg_d   = (op_i == OP_SDEC) && low[31];
          if (op_i == OP_SDEC || op_i == OP_UDEC) begin
            work_d = {32'b0, mag};
            pre_d  = ((op_i == OP_SDEC) && low[31]) ? 2'd1 : 2'd0;
          end else begin
            work_d = value_i;
            pre_d  = (op_i == OP_PTR) ? 2'd2 : 2'd0;
          end
        end
      end
      ST_MUL: begin
      end
      ST_DIV: begin
        dig_we    = 1'b1;
        dig_wdata = rem;
        ndig_d    = ndig_q + 5'd1;
        work_d    = {32'b0, quot};
      end
      ST_HEX: begin
        dig_we    = 1'b1;
        dig_wdata = work_q[3:0];
        ndig_d    = ndig_q + 5'd1;
        work_d    = {4'b0, work_q[63:4]};
      end
      ST_EMIT: begin
        ob_load = 1'b1;
        if (ob_ready) begin
          pos_d = pos_q + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    ndig_q  <= ndig_d;
    pos_q   <= pos_d;
    pre_q   <= pre_d;
    neg_q   <= neg_d;
    upper_q <= upper_d;
    if (dig_we) begin
      dig_q[ndig_q[DigIdxW-1:0]] <= dig_wdata;
    end
  end

  itoa_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ob_load),
    .beat_i      (beat_d),
    .ready_o     (ob_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .beat_o      (beat_o)
  );

  assign char_out_o = beat_o.char_out;
  assign position_o = beat_o.position;
  assign last_o     = beat_o.last;

endmodule

`default_nettype wire

// ----- rtl/itoa_divu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module itoa_divu (
  input  wire logic        clk_i,
  input  wire logic [31:0] x_i,
  output logic      [31:0] quot_o,
  output logic      [3:0]  rem_o
);
  import itoa_pkg::*;

  logic [63:0] prod_q;
  logic [31:0] x_q;
  logic [31:0] qt10;
  logic [31:0] diff;

  always_ff @(posedge clk_i) begin
    prod_q <= {32'b0, x_i} * {32'b0, RECIP10};
    x_q    <= x_i;
  end

  assign quot_o = {3'b0, prod_q[63:35]};
  assign qt10   = {quot_o[28:0], 3'b0} + {quot_o[30:0], 1'b0};
  assign diff   = x_q - qt10;
  assign rem_o  = diff[3:0];

endmodule

`default_nettype wire

// ----- rtl/itoa_obuf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module itoa_obuf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire itoa_pkg::beat_t beat_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output itoa_pkg::beat_t      beat_o
);
  import itoa_pkg::*;

  logic  valid_q, valid_d;
  beat_t beat_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      beat_q <= beat_i;
    end
  end

  assign out_valid_o = valid_q;
  assign beat_o      = beat_q;

endmodule

`default_nettype wire

// ----- rtl/itoa_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module itoa_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [2:0]  op_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  char_out_o,
  input wire logic [4:0]  position_o,
  input wire logic        last_o
);
  import itoa_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_out_o)
      && $stable(position_o) && $stable(last_o))
    else $error("stalled output beat changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i <= OP_PTR) |=> in_stall_o)
    else $error("valid item accepted but block not busy");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_stall_o |-> last_o)
    else $error("input ready while a run is still open");

  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (position_o <= 5'd17) && !(position_o == 5'd0 && char_out_o == CH_X))
    else $error("bad position or first character");

endmodule

bind integer_to_ascii_formatter itoa_chk u_itoa_chk (.*);

`default_nettype wire

// ----- verif/tb_integer_to_ascii_formatter.sv -----
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;
  import itoa_pkg::*;

  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;
  localparam int MAX_CHARS = 18;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_PER_PHASE = 56;
  localparam string LOWER_DIGITS = "0123456789abcdef";
  localparam string UPPER_DIGITS = "0123456789ABCDEF";

  typedef struct {
    logic [2:0]  op;
    logic [63:0] value;
    bit          typed;
    string       text;
  } row_t;

  localparam int N_ROWS = 24;
  row_t directed_rows [0:N_ROWS-1] = '{
    '{OP_SDEC,   64'd0,                    1'b1, "0"},
    '{OP_SDEC,   64'h0000_0000_8000_0000,  1'b1, "-2147483648"},
    '{OP_SDEC,   64'h0000_0000_7FFF_FFFF,  1'b1, "2147483647"},
    '{OP_SDEC,   64'h0000_0000_FFFF_FFFF,  1'b1, "-1"},
    '{OP_SDEC,   64'hFFFF_FFFF_0000_0005,  1'b1, "5"},
    '{OP_SDEC,   64'd10,                   1'b0, ""},
    '{OP_SDEC,   64'h0000_0000_FFFF_FFF6,  1'b0, ""},
    '{OP_UDEC,   64'd0,                    1'b1, "0"},
    '{OP_UDEC,   64'h0000_0000_FFFF_FFFF,  1'b1, "4294967295"},
    '{OP_UDEC,   64'h0000_0000_8000_0000,  1'b0, ""},
    '{OP_UDEC,   64'd1000000000,           1'b0, ""},
    '{OP_HEXL,   64'd0,                    1'b1, "0"},
    '{OP_HEXL,   64'hFFFF_FFFF_FFFF_FFFF,  1'b1, "ffffffffffffffff"},
    '{OP_HEXL,   64'h0123_4567_89AB_CDEF,  1'b0, ""},
    '{OP_HEXU,   64'd0,                    1'b1, "0"},
    '{OP_HEXU,   64'hFFFF_FFFF_FFFF_FFFF,  1'b1, "FFFFFFFFFFFFFFFF"},
    '{OP_HEXU,   64'hFEDC_BA98_7654_3210,  1'b0, ""},
    '{OP_PTR,    64'd0,                    1'b1, "0x0"},
    '{OP_PTR,    64'hFFFF_FFFF_FFFF_FFFF,  1'b1, "0xffffffffffffffff"},
    '{OP_PTR,    64'h8000_0000_0000_0000,  1'b1, "0x8000000000000000"},
    '{OP_PTR,    64'hA,                    1'b0, ""},
    '{OP_BAD_LO, 64'd0,                    1'b1, ""},
    '{3'd6,      64'hFFFF_FFFF_FFFF_FFFF,  1'b1, ""},
    '{OP_BAD_HI, 64'h1234,                 1'b1, ""}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  op_i = OP_SDEC;
  logic [63:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  char_out_o;
  logic [4:0]  position_o;
  logic        last_o;

  beat_t expected_chars [$];
  int    fails = 0;
  int    stuck_cycles = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  integer_to_ascii_formatter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .char_out_o (char_out_o),
    .position_o (position_o),
    .last_o     (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void push_text(input logic [7:0] text [0:MAX_CHARS-1], input int len);
    for (int k = 0; k < len; k++) begin
      expected_chars.push_back('{char_out: text[k], position: 5'(k), last: (k == len - 1)});
    end
  endfunction

  // Expected characters of one item; undefined selectors give nothing.
  function automatic void format_number(input logic [2:0] op, input logic [63:0] value);
    logic [7:0]  text [0:MAX_CHARS-1];
    logic [7:0]  rev [0:19];
    logic [31:0] low;
    logic [63:0] mag;
    logic [63:0] radix;
    string       digit_set;
    int          len;
    int          n;
    len = 0;
    n = 0;
    low = value[31:0];
    mag = value;
    radix = 64'd16;
    digit_set = LOWER_DIGITS;
    case (op)
      OP_SDEC: begin
        if (low[31]) begin
          text[len] = CH_MINUS;
          len += 1;
          low = -low;
        end
        mag = {32'd0, low};
        radix = 64'd10;
      end
      OP_UDEC: begin
        mag = {32'd0, low};
        radix = 64'd10;
      end
      OP_HEXL: ;
      OP_HEXU: digit_set = UPPER_DIGITS;
      OP_PTR: begin
        text[0] = CH_ZERO;
        text[1] = CH_X;
        len = 2;
      end
      default: return;
    endcase
    do begin
      rev[n] = digit_set[int'(mag % radix)];
      mag = mag / radix;
      n += 1;
    end while (mag != 0);
    for (int k = 0; k < n; k++) begin
      text[len + k] = rev[n - 1 - k];
    end
    push_text(text, len + n);
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [63:0] p;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: ;
      1: v = 64'($urandom_range(20));
      2: begin
        v = 64'd1 << $urandom_range(63);
        if ($urandom_range(1) == 1) v = v - 64'd1;
      end
      3: begin
        p = 64'd1;
        repeat ($urandom_range(9)) p = p * 64'd10;
        v[31:0] = 32'(p + 64'($urandom_range(2)) - 64'd1);
      end
      4: v[31:0] = 32'h7FFF_FFFE + 32'($urandom_range(3));
      default: v = v >> $urandom_range(63);
    endcase
    return v;
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [63:0] value,
                           input bit typed, input string text);
    logic [7:0] chars [0:MAX_CHARS-1];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    value_i <= value;
    do begin
      @(posedge clk_i);
    end while (!(in_valid_i && !in_stall_o));
    if (typed) begin
      for (int k = 0; k < text.len(); k++) chars[k] = text[k];
      push_text(chars, text.len());
    end else begin
      format_number(op, value);
    end
  endtask

  task automatic run_random(input int in_pct, input int out_pct);
    logic [2:0] op;
    int         sent;
    send_idle_pct = in_pct;
    recv_stall_pct = out_pct;
    sent = 0;
    while (sent < RANDOM_PER_PHASE) begin
      if ($urandom_range(19) == 0) begin
        op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
      end else begin
        op = 3'($urandom_range(OP_SDEC, OP_PTR));
        sent += 1;
      end
      send_item(op, random_value(), 1'b0, "");
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected beat char=%h pos=%0d last=%b",
                 $time, char_out_o, position_o, last_o);
        fails += 1;
      end else begin
        if (char_out_o !== expected_chars[0].char_out ||
            position_o !== expected_chars[0].position ||
            last_o !== expected_chars[0].last) begin
          $display("%0t: mismatch exp char=%h pos=%0d last=%b got char=%h pos=%0d last=%b",
                   $time, expected_chars[0].char_out, expected_chars[0].position,
                   expected_chars[0].last, char_out_o, position_o, last_o);
          fails += 1;
        end
        void'(expected_chars.pop_front());
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < N_ROWS; i++) begin
      send_item(directed_rows[i].op, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].text);
    end
    run_random(0, 0);
    run_random(53, 0);
    run_random(0, 53);
    run_random(30, 30);
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
